### sv/nwc_pkg.sv
// Package for the neighbor wake cache.
// Field widths, function codes and parameter defaults shared by the interfaces
// and the top level. No dependencies.
package nwc_pkg;

    localparam int FUNC_W = 1;
    localparam int ID_W   = 8;
    localparam int IVAL_W = 16;
    localparam int NOW_W  = 32;

    localparam int DEFAULT_NEIGHBOR_SLOTS = 10;
    localparam int DEFAULT_TIME_BITS      = 32;

    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

    localparam logic [ID_W-1:0] FREE_ID = '0;

endpackage

### sv/nwc_if.sv
// Valid/ready channel interfaces for the neighbor wake cache.
// Depends on nwc_pkg for the field widths.
interface nwc_in_if
    import nwc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   node_id;
    logic [IVAL_W-1:0] wake_period;
    logic [NOW_W-1:0]  now;

    modport source (output valid, func, node_id, wake_period, now, input ready);
    modport sink   (input valid, func, node_id, wake_period, now, output ready);
endinterface

interface nwc_out_if
    import nwc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic [IVAL_W-1:0] wait_ticks;
    logic              table_full;

    modport source (output valid, found, wait_ticks, table_full, input ready);
    modport sink   (input valid, found, wait_ticks, table_full, output ready);
endinterface

### sv/neighbor_wake_cache.sv
// Neighbor wake cache top level: slot table, scan sequencer and serial divider.
// Depends on nwc_pkg and the channel interfaces in nwc_if.sv.
//
// Usage:
//   item   : sink channel. func selects a beacon update or a wake query;
//            node_id, wake_period and now travel with it. One transfer is
//            taken while the block is idle; ready is low until the result of
//            that item has been taken.
//   result : source channel. Exactly one transfer per item, carrying found,
//            wait_ticks and table_full. The result register holds its value
//            while the receiver stalls, and no new item enters meanwhile.
// Sequence: the sequencer reads one slot per cycle across all NEIGHBOR_SLOTS
//   slots. At the last slot an update writes the hit or first free slot (none
//   when the table is full) and shows the result in the next cycle. A query
//   that hits an entry with a nonzero interval then runs a restoring divider,
//   one quotient bit per cycle, over the TIME_BITS-bit elapsed time; other
//   queries go straight to the result. After the result is taken the block
//   returns to idle before the next item is taken.
// Reset clears every slot to free with zero time and interval, and drops
//   any item in flight.
module neighbor_wake_cache
    import nwc_pkg::*;
#(
    parameter int NEIGHBOR_SLOTS = DEFAULT_NEIGHBOR_SLOTS,
    parameter int TIME_BITS      = DEFAULT_TIME_BITS
)(
    input  logic clk,
    input  logic rst_n,
    nwc_in_if.sink    item,
    nwc_out_if.source result
);

    // Stored times keep only the bits that survive both the time mask and
    // the 32-bit store.
    localparam int SEEN_W   = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
    localparam int IDX_W    = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
    localparam int DIV_W    = $clog2(TIME_BITS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEIGHBOR_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Slot table
    logic [ID_W-1:0]   slot_id_reg       [NEIGHBOR_SLOTS];
    logic [SEEN_W-1:0] slot_last_seen_reg[NEIGHBOR_SLOTS];
    logic [IVAL_W-1:0] slot_interval_reg [NEIGHBOR_SLOTS];

    // Captured item
    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [IVAL_W-1:0] ival_reg;
    logic [SEEN_W-1:0] now_reg;

    // Scan bookkeeping
    logic [IDX_W-1:0]  scan_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [SEEN_W-1:0] hit_seen_reg;
    logic [IVAL_W-1:0] hit_ival_reg;

    // Divider
    logic [TIME_BITS-1:0] dividend_reg;
    logic [IVAL_W-1:0]    rem_reg;
    logic [DIV_W-1:0]     div_cnt_reg;

    // Result register
    logic              found_reg;
    logic [IVAL_W-1:0] wait_reg;
    logic              full_reg;

    // Slot under the scan pointer
    logic [ID_W-1:0]   rd_id;
    logic [SEEN_W-1:0] rd_seen;
    logic [IVAL_W-1:0] rd_ival;
    logic              match_now;
    logic              free_now;

    // Scan results including the current slot
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_any;
    logic [IDX_W-1:0]  free_idx;
    logic [SEEN_W-1:0] seen_sel;
    logic [IVAL_W-1:0] ival_sel;
    logic [TIME_BITS-1:0] elapsed;

    // One restoring step
    logic [IVAL_W:0]   rem_shift;
    logic [IVAL_W:0]   rem_diff;
    logic              rem_ge;
    logic [IVAL_W-1:0] rem_next;

    always_comb
    begin
        rd_id     = slot_id_reg[scan_reg];
        rd_seen   = slot_last_seen_reg[scan_reg];
        rd_ival   = slot_interval_reg[scan_reg];
        match_now = (rd_id == id_reg);
        free_now  = (rd_id == FREE_ID);

        // First match wins: keep an earlier hit over the current slot.
        hit_any  = hit_reg | match_now;
        hit_idx  = hit_reg ? hit_idx_reg : scan_reg;
        free_any = free_reg | free_now;
        free_idx = free_reg ? free_idx_reg : scan_reg;
        seen_sel = hit_reg ? hit_seen_reg : rd_seen;
        ival_sel = hit_reg ? hit_ival_reg : rd_ival;

        // Elapsed time wraps modulo 2^TIME_BITS.
        elapsed  = TIME_BITS'(now_reg) - TIME_BITS'(seen_sel);

        rem_shift = {rem_reg, dividend_reg[TIME_BITS-1]};
        rem_diff  = rem_shift - {1'b0, hit_ival_reg};
        rem_ge    = (rem_shift >= {1'b0, hit_ival_reg});
        rem_next  = rem_ge ? rem_diff[IVAL_W-1:0] : rem_shift[IVAL_W-1:0];
    end

    assign item.ready        = (state_reg == ST_IDLE);
    assign result.valid      = (state_reg == ST_OUT);
    assign result.found      = found_reg;
    assign result.wait_ticks = wait_reg;
    assign result.table_full = full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NEIGHBOR_SLOTS; i++)
            begin
                slot_id_reg[i]        <= FREE_ID;
                slot_last_seen_reg[i] <= '0;
                slot_interval_reg[i]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        func_reg  <= item.func;
                        id_reg    <= item.node_id;
                        ival_reg  <= item.wake_period;
                        now_reg   <= item.now[SEEN_W-1:0];
                        scan_reg  <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    // Advance one slot per cycle, latching the first hit and free slot.
                    hit_reg      <= hit_any;
                    hit_idx_reg  <= hit_idx;
                    free_reg     <= free_any;
                    free_idx_reg <= free_idx;
                    hit_seen_reg <= seen_sel;
                    hit_ival_reg <= ival_sel;

                    if (scan_reg != LAST_IDX)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    else if (func_reg == FUNC_UPDATE)
                    begin
                        found_reg <= hit_any;
                        wait_reg  <= '0;
                        full_reg  <= !hit_any && !free_any;
                        if (hit_any)
                        begin
                            slot_id_reg[hit_idx]        <= id_reg;
                            slot_last_seen_reg[hit_idx] <= now_reg;
                            slot_interval_reg[hit_idx]  <= ival_reg;
                        end
                        else if (free_any)
                        begin
                            slot_id_reg[free_idx]        <= id_reg;
                            slot_last_seen_reg[free_idx] <= now_reg;
                            slot_interval_reg[free_idx]  <= ival_reg;
                        end
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        found_reg <= hit_any;
                        full_reg  <= 1'b0;
                        wait_reg  <= '0;
                        if (hit_any && (ival_sel != '0))
                        begin
                            dividend_reg <= elapsed;
                            rem_reg      <= '0;
                            div_cnt_reg  <= DIV_W'(TIME_BITS);
                            state_reg    <= ST_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end

                ST_DIV:
                begin
                    // One quotient bit per cycle; only the remainder is kept.
                    dividend_reg <= {dividend_reg[TIME_BITS-2:0], 1'b0};
                    rem_reg      <= rem_next;
                    div_cnt_reg  <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == DIV_W'(1))
                    begin
                        wait_reg  <= hit_ival_reg - rem_next;
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    // Hold the result until the receiver takes the transfer.
                    if (result.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
